[rtl/core/chte_pkg.sv]
// Package: shared types, constants and opcode/status codes for the chained hash table engine.
package chte_pkg;

    localparam int unsigned DEF_MAX_BUCKETS = 256;
    localparam int unsigned DEF_POOL_NODES  = 1024;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned TOTAL_W = 11;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [VAL_W-1:0]   value_out;
        logic [TOTAL_W-1:0] entry_total;
    } t_rsp;

endpackage

[rtl/core/chte_mod_unit.sv]
// Bit-serial remainder unit: key modulo bucket count, one quotient bit per cycle.
module chte_mod_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [chte_pkg::KEY_W-1:0] i_dividend,
    input  logic [chte_pkg::CFG_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [chte_pkg::CFG_W-1:0] o_rem
);
    import chte_pkg::*;

    localparam int unsigned CNT_W = $clog2(KEY_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_num;
    logic [CFG_W:0]   r_rem;
    logic [CFG_W-1:0] r_div;
    logic             r_done;
    logic [CFG_W:0]   w_shift;

    assign w_shift = {r_rem[CFG_W-1:0], r_num[KEY_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KEY_W);
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // subtract when the shifted partial remainder reaches the divisor
                if (w_shift >= {1'b0, r_div}) begin
                    r_rem <= w_shift - {1'b0, r_div};
                end else begin
                    r_rem <= w_shift;
                end
                r_num <= {r_num[KEY_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[CFG_W-1:0];

endmodule

[rtl/core/chte_node_ram.sv]
// Node pool memory: one entry holds key, value and link; one write and one registered read port.
module chte_node_ram #(
    parameter int unsigned POOL_NODES = chte_pkg::DEF_POOL_NODES,
    parameter int unsigned LINK_W     = $clog2(POOL_NODES + 1),
    parameter int unsigned ADDR_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [ADDR_W-1:0]                         i_waddr,
    input  logic [chte_pkg::KEY_W+chte_pkg::VAL_W+LINK_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]                         i_raddr,
    output logic [chte_pkg::KEY_W+chte_pkg::VAL_W+LINK_W-1:0] o_rdata
);
    import chte_pkg::*;

    localparam int unsigned WORD_W = KEY_W + VAL_W + LINK_W;

    logic [WORD_W-1:0] r_mem [POOL_NODES];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/chained_hash_table_engine.sv]
// Top level: chained hash table sequencer with bucket heads, free list and node pool.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   request | in        | i_req_valid/o_req_stall | opcode, key, value_in
//   result  | out       | o_rsp_valid/i_rsp_stall | status, value_out, entry_total
//   config  | in        | i_cfg_we            | bucket_count (9 bits)
//
// For each transaction a bit-serial remainder sets the bucket, then the chain walk
// reads one node per memory access. Reset is synchronous and active low; after it
// the bucket table reads empty through per-bucket valid bits, no clearing pass.
// A stalled result holds in its output register; the next request is taken
// only after the result has left.
module chained_hash_table_engine #(
    parameter int unsigned MAX_BUCKETS = chte_pkg::DEF_MAX_BUCKETS,
    parameter int unsigned POOL_NODES  = chte_pkg::DEF_POOL_NODES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_stall,
    input  chte_pkg::t_req                 i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_stall,
    output chte_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [chte_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import chte_pkg::*;

    localparam int unsigned LINK_W = $clog2(POOL_NODES + 1);
    localparam int unsigned ADDR_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int unsigned BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int unsigned WORD_W = KEY_W + VAL_W + LINK_W;
    localparam int unsigned STEP_W = $clog2(POOL_NODES + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);
    localparam logic [CFG_W-1:0]  CFG_MAX = (MAX_BUCKETS >= 256) ? CFG_W'(256)
                                                                  : CFG_W'(MAX_BUCKETS);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_HEAD, S_CHECK, S_WAIT, S_EVAL, S_FREE_RD, S_FREE_WAIT,
        S_INSERT, S_UNLINK, S_OUT
    } t_state;

    t_state r_state;
    t_req   r_req;
    t_rsp   r_rsp;
    logic   r_rsp_valid;

    logic [CFG_W-1:0]   r_bcount;
    logic [LINK_W-1:0]  r_heads [MAX_BUCKETS];
    logic               r_hvalid [MAX_BUCKETS];
    logic [LINK_W-1:0]  r_head_rd;
    logic [LINK_W-1:0]  r_free_head;
    logic [LINK_W-1:0]  r_fresh;
    logic [TOTAL_W-1:0] r_count;
    logic [BKT_W-1:0]   r_bkt;
    logic [LINK_W-1:0]  r_cur;
    logic [LINK_W-1:0]  r_prev;
    logic [STEP_W-1:0]  r_steps;
    logic [KEY_W-1:0]   r_prev_key;
    logic [VAL_W-1:0]   r_prev_val;

    logic               w_mod_start;
    logic               w_mod_done;
    logic [CFG_W-1:0]   w_rem;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [WORD_W-1:0]  w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [WORD_W-1:0]  w_rdata;
    logic [KEY_W-1:0]   w_nkey;
    logic [VAL_W-1:0]   w_nval;
    logic [LINK_W-1:0]  w_nlink;
    logic [LINK_W-1:0]  w_head;
    logic [BKT_W-1:0]   w_head_addr;
    logic               w_req_take;

    assign {w_nkey, w_nval, w_nlink} = w_rdata;
    assign w_head = r_head_rd;
    assign w_req_take  = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != S_IDLE) || r_rsp_valid;
    assign w_mod_start = (r_state == S_MOD) && (r_steps == '0);

    chte_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_req.key),
        .i_divisor  (r_bcount),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    chte_node_ram #(
        .POOL_NODES (POOL_NODES),
        .LINK_W     (LINK_W),
        .ADDR_W     (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Bucket head read: registered; address the new bucket as the remainder lands,
    // then hold on the current bucket so the head is ready in S_HEAD and S_INSERT.
    assign w_head_addr = (r_state == S_MOD && w_mod_done) ? BKT_W'(w_rem) : r_bkt;

    always_ff @(posedge i_clk) begin
        r_head_rd <= r_hvalid[w_head_addr] ? r_heads[w_head_addr] : NIL;
    end

    // Read address: chain node in walk, free head when popping.
    always_comb begin
        w_raddr = r_cur[ADDR_W-1:0];
        if (r_state == S_FREE_RD) begin
            w_raddr = r_free_head[ADDR_W-1:0];
        end
    end

    // Node writes: fill on insert, relink predecessor and push freed node on remove.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur[ADDR_W-1:0];
        w_wdata = {r_prev_key, r_prev_val, r_free_head};
        if (r_state == S_INSERT) begin
            w_we    = 1'b1;
            w_waddr = r_prev[ADDR_W-1:0];
            w_wdata = {r_req.key, r_req.value_in, w_head};
        end else if (r_state == S_EVAL && r_req.opcode == OP_REMOVE
                     && r_cur != NIL && w_nkey == r_req.key && r_prev != NIL) begin
            w_we    = 1'b1;
            w_waddr = r_prev[ADDR_W-1:0];
            w_wdata = {r_prev_key, r_prev_val, w_nlink};
        end else if (r_state == S_UNLINK) begin
            w_we    = 1'b1;
            w_waddr = r_cur[ADDR_W-1:0];
            w_wdata = {r_req.key, r_prev_val, r_free_head};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_bcount    <= CFG_MAX;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_steps     <= '0;
            for (int i = 0; i < int'(MAX_BUCKETS); i++) begin
                r_hvalid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                // clamp out-of-range counts
                if (i_cfg_wdata == '0) begin
                    r_bcount <= CFG_W'(1);
                end else if (i_cfg_wdata > CFG_MAX) begin
                    r_bcount <= CFG_MAX;
                end else begin
                    r_bcount <= i_cfg_wdata;
                end
            end
            if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_req_take) begin
                        r_req   <= i_req;
                        r_steps <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_steps <= STEP_W'(1);
                    if (w_mod_done) begin
                        // remainder is already below the bucket count
                        r_bkt   <= BKT_W'(w_rem);
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_cur   <= w_head;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_rsp.status    <= ST_NOT_FOUND;
                    r_rsp.value_out <= '0;
                    if (r_req.opcode == OP_INSERT && r_free_head == NIL && r_fresh == NIL) begin
                        r_rsp.status <= ST_POOL_FULL;
                        r_state      <= S_OUT;
                    end else if (r_req.opcode == OP_LOOKUP || r_req.opcode == OP_INSERT
                                 || r_req.opcode == OP_REMOVE) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CHECK: begin
                    // end of chain or walk bound reached: no match
                    if (r_cur == NIL || r_steps == STEP_W'(POOL_NODES)) begin
                        if (r_req.opcode == OP_INSERT) begin
                            r_prev  <= r_fresh;
                            r_state <= (r_free_head != NIL) ? S_FREE_RD : S_INSERT;
                            if (r_free_head == NIL) begin
                                r_fresh <= r_fresh + 1'b1;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_nkey == r_req.key) begin
                        case (r_req.opcode)
                            OP_LOOKUP: begin
                                r_rsp.status    <= ST_OK;
                                r_rsp.value_out <= w_nval;
                                r_state         <= S_OUT;
                            end
                            OP_INSERT: begin
                                r_rsp.status <= ST_DUPLICATE;
                                r_state      <= S_OUT;
                            end
                            default: begin
                                if (r_prev == NIL) begin
                                    r_heads[r_bkt]  <= w_nlink;
                                    r_hvalid[r_bkt] <= 1'b1;
                                end
                                r_prev_val <= w_nval;
                                r_state    <= S_UNLINK;
                            end
                        endcase
                    end else begin
                        r_prev      <= r_cur;
                        r_prev_key  <= w_nkey;
                        r_prev_val  <= w_nval;
                        r_cur       <= w_nlink;
                        r_steps     <= r_steps + 1'b1;
                        r_state     <= S_CHECK;
                    end
                end
                S_FREE_RD: begin
                    r_prev  <= r_free_head;
                    r_state <= S_FREE_WAIT;
                end
                S_FREE_WAIT: begin
                    r_free_head <= w_nlink;
                    r_state     <= S_INSERT;
                end
                S_INSERT: begin
                    r_heads[r_bkt]  <= r_prev;
                    r_hvalid[r_bkt] <= 1'b1;
                    r_count         <= r_count + 1'b1;
                    r_rsp.status    <= ST_OK;
                    r_state         <= S_OUT;
                end
                S_UNLINK: begin
                    r_free_head  <= r_cur;
                    r_count      <= (r_count != '0) ? r_count - 1'b1 : r_count;
                    r_rsp.status <= ST_OK;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    r_rsp.entry_total <= r_count;
                    r_rsp_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // A result never appears while a request is still in work.
    a_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (r_state == S_IDLE))
        else $error("result valid while busy");

    // Accepting a request starts the bucket computation.
    a_take_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_take |=> (r_state == S_MOD))
        else $error("accepted request did not start");

    // The entry count never exceeds the pool.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= TOTAL_W'(POOL_NODES))
        else $error("entry count beyond pool");

    // A held result stays while stalled.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled result changed");

endmodule
